FILE: src/dbcm_pkg.sv
// Shared types, constants and the colour table for the dB to colour map.
// Depends on nothing; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package dbcm_pkg;

   // Fixed-point format of the level and of the table position
   localparam int FRAC_BITS  = 8;
   localparam int LEVEL_W    = 19;
   localparam int SCALE_W    = 16;
   localparam int MAG_W      = LEVEL_W;
   localparam int POS_W      = MAG_W + SCALE_W;
   localparam int POS_FRAC   = FRAC_BITS + SCALE_W;
   localparam int ROW_W      = POS_W - POS_FRAC;
   localparam int BLEND_W    = 8;
   localparam int ROWS       = 19;
   localparam int LAST_ROW   = ROWS - 1;
   localparam int IDX_W      = $clog2(ROWS);
   localparam int SUM_W      = 17;

   localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(6554);

   typedef logic signed [LEVEL_W-1:0] level_type;
   typedef logic [7:0]                byte_type;

   typedef struct packed {
      byte_type red;
      byte_type green;
      byte_type blue;
   } rgb_type;

   localparam rgb_type RGB_WHITE = '{red: 8'd255, green: 8'd255, blue: 8'd255};
   localparam rgb_type RGB_BLACK = '{red: 8'd0, green: 8'd0, blue: 8'd0};

   // Colour table, white at row 0 fading to black at the last row
   function automatic rgb_type palette_row(input logic [IDX_W-1:0] idx);
      rgb_type row;
      unique case (idx)
         5'd0:    row = '{8'd255, 8'd255, 8'd255};
         5'd1:    row = '{8'd240, 8'd254, 8'd216};
         5'd2:    row = '{8'd242, 8'd251, 8'd185};
         5'd3:    row = '{8'd253, 8'd245, 8'd143};
         5'd4:    row = '{8'd253, 8'd200, 8'd102};
         5'd5:    row = '{8'd252, 8'd144, 8'd66};
         5'd6:    row = '{8'd252, 8'd75,  8'd32};
         5'd7:    row = '{8'd237, 8'd28,  8'd41};
         5'd8:    row = '{8'd214, 8'd3,   8'd64};
         5'd9:    row = '{8'd183, 8'd3,   8'd101};
         5'd10:   row = '{8'd157, 8'd3,   8'd122};
         5'd11:   row = '{8'd122, 8'd3,   8'd126};
         5'd12:   row = '{8'd80,  8'd2,   8'd110};
         5'd13:   row = '{8'd45,  8'd2,   8'd89};
         5'd14:   row = '{8'd19,  8'd2,   8'd70};
         5'd15:   row = '{8'd1,   8'd3,   8'd53};
         5'd16:   row = '{8'd1,   8'd3,   8'd37};
         5'd17:   row = '{8'd1,   8'd2,   8'd19};
         default: row = '{8'd0,   8'd0,   8'd0};
      endcase
      return row;
   endfunction

   // Round-half-up linear blend of two bytes by an 8-bit fraction
   function automatic byte_type blend(input byte_type a, input byte_type b,
                                      input byte_type f);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(a) * (SUM_W'(256) - SUM_W'(f)) + SUM_W'(b) * SUM_W'(f)
            + SUM_W'(128);
      return sum[15:8];
   endfunction

endpackage

FILE: src/dbcm_if.sv
// Valid/ready channel interfaces for level beats in and colour beats out.
// Depends on dbcm_pkg.
`timescale 1ns / 1ps

interface dbcm_req_if;
   logic               valid;
   logic               ready;
   dbcm_pkg::level_type level_db;

   modport source (output valid, output level_db, input ready);
   modport sink   (input valid, input level_db, output ready);
endinterface

interface dbcm_rsp_if;
   logic              valid;
   logic              ready;
   dbcm_pkg::byte_type red;
   dbcm_pkg::byte_type green;
   dbcm_pkg::byte_type blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: src/db_to_colour_map_top.sv
// An accepted level beat is registered in stages 1, 2 and 3, then in the output register.
// Throughput: one beat per cycle; the four stages advance together whenever the
// output register is empty or its beat is taken, so a stall holds every stage.
// Reset: synchronous, active high; clears all valid bits and sets the position scale
// register to 6554. Depends on dbcm_pkg and dbcm_if.
`timescale 1ns / 1ps

module db_to_colour_map_top (
   input  logic                          clock,
   input  logic                          reset,
   dbcm_req_if.sink                      req_ch,
   dbcm_rsp_if.source                    rsp_ch,
   input  logic                          csr_write_enable,
   input  logic [dbcm_pkg::SCALE_W-1:0]  csr_write_data
);

   // Position scale register
   logic [dbcm_pkg::SCALE_W-1:0] scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= dbcm_pkg::SCALE_RESET;
      end else if (csr_write_enable) begin
         scale_ff <= csr_write_data;
      end
   end

   // Global advance: move every stage when the output slot frees up
   logic advance;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;

   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_ch.valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   // Stage 1: sign test and magnitude
   logic                         s1_white_in, s1_white_ff;
   logic [dbcm_pkg::MAG_W-1:0]   s1_mag_in, s1_mag_ff;

   assign s1_white_in = !req_ch.level_db[dbcm_pkg::LEVEL_W-1];
   assign s1_mag_in   = dbcm_pkg::MAG_W'(-req_ch.level_db);

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_white_ff <= s1_white_in;
         s1_mag_ff   <= s1_mag_in;
      end
   end

   // Stage 2: table position = magnitude times scale
   logic                         s2_white_ff;
   logic [dbcm_pkg::POS_W-1:0]   s2_pos_in, s2_pos_ff;

   assign s2_pos_in = dbcm_pkg::POS_W'(s1_mag_ff) * dbcm_pkg::POS_W'(scale_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_white_ff <= s1_white_ff;
         s2_pos_ff   <= s2_pos_in;
      end
   end

   // Stage 3: row index, fraction and table lookup; force white or black ends
   logic [dbcm_pkg::ROW_W-1:0] row;
   logic [dbcm_pkg::IDX_W-1:0] idx;
   logic                       black;
   dbcm_pkg::rgb_type          s3_a_in, s3_b_in, s3_a_ff, s3_b_ff;
   dbcm_pkg::byte_type         s3_f_in, s3_f_ff;

   assign row   = s2_pos_ff[dbcm_pkg::POS_W-1:dbcm_pkg::POS_FRAC];
   assign black = row >= dbcm_pkg::ROW_W'(dbcm_pkg::LAST_ROW);
   assign idx   = row[dbcm_pkg::IDX_W-1:0];

   always_comb begin
      if (s2_white_ff) begin
         s3_a_in = dbcm_pkg::RGB_WHITE;
         s3_b_in = dbcm_pkg::RGB_WHITE;
         s3_f_in = '0;
      end else if (black) begin
         s3_a_in = dbcm_pkg::RGB_BLACK;
         s3_b_in = dbcm_pkg::RGB_BLACK;
         s3_f_in = '0;
      end else begin
         s3_a_in = dbcm_pkg::palette_row(idx);
         s3_b_in = dbcm_pkg::palette_row(idx + dbcm_pkg::IDX_W'(1));
         s3_f_in = s2_pos_ff[dbcm_pkg::POS_FRAC-1 -: dbcm_pkg::BLEND_W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_a_ff <= s3_a_in;
         s3_b_ff <= s3_b_in;
         s3_f_ff <= s3_f_in;
      end
   end

   // Stage 4: blend each channel into the output register
   dbcm_pkg::rgb_type out_in, out_ff;

   assign out_in.red   = dbcm_pkg::blend(s3_a_ff.red,   s3_b_ff.red,   s3_f_ff);
   assign out_in.green = dbcm_pkg::blend(s3_a_ff.green, s3_b_ff.green, s3_f_ff);
   assign out_in.blue  = dbcm_pkg::blend(s3_a_ff.blue,  s3_b_ff.blue,  s3_f_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.red   = out_ff.red;
   assign rsp_ch.green = out_ff.green;
   assign rsp_ch.blue  = out_ff.blue;

endmodule

FILE: dv/testbench.sv
// Self-checking bench for db_to_colour_map_top: random level beats, random stalls.
// A local colour predictor checks each colour beat. Depends on dbcm_pkg, dbcm_if and the top.
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned         CYCLE_LIMIT = 500000;
   localparam int unsigned         PHASE_BEATS = 150;
   localparam dbcm_pkg::level_type LEVEL_LOW   = dbcm_pkg::level_type'(-262144);
   localparam dbcm_pkg::level_type LEVEL_HIGH  = dbcm_pkg::level_type'(262143);

   typedef struct {
      dbcm_pkg::level_type level;
      dbcm_pkg::rgb_type   colour;
   } colour_beat_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [dbcm_pkg::SCALE_W-1:0] csr_write_data;

   dbcm_req_if req_bus ();
   dbcm_rsp_if rsp_bus ();

   db_to_colour_map_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_bus),
      .rsp_ch           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   dbcm_pkg::level_type          level_queue [$];
   colour_beat_type              colour_expect [$];
   logic [dbcm_pkg::SCALE_W-1:0] scale_shadow;
   int unsigned                  mismatch_count;
   int unsigned                  cycle_count;
   int unsigned                  req_wait;
   int unsigned                  rsp_wait;
   bit                           req_calm;
   bit                           rsp_calm;

   // Colour table as {red, green, blue}, white at the top fading to black
   function automatic logic [23:0] shade_row(input int unsigned r);
      case (r)
         0:       return {8'd255, 8'd255, 8'd255};
         1:       return {8'd240, 8'd254, 8'd216};
         2:       return {8'd242, 8'd251, 8'd185};
         3:       return {8'd253, 8'd245, 8'd143};
         4:       return {8'd253, 8'd200, 8'd102};
         5:       return {8'd252, 8'd144, 8'd66};
         6:       return {8'd252, 8'd75,  8'd32};
         7:       return {8'd237, 8'd28,  8'd41};
         8:       return {8'd214, 8'd3,   8'd64};
         9:       return {8'd183, 8'd3,   8'd101};
         10:      return {8'd157, 8'd3,   8'd122};
         11:      return {8'd122, 8'd3,   8'd126};
         12:      return {8'd80,  8'd2,   8'd110};
         13:      return {8'd45,  8'd2,   8'd89};
         14:      return {8'd19,  8'd2,   8'd70};
         15:      return {8'd1,   8'd3,   8'd53};
         16:      return {8'd1,   8'd3,   8'd37};
         17:      return {8'd1,   8'd2,   8'd19};
         default: return 24'd0;
      endcase
   endfunction

   // Linear mix of two bytes, rounded half up
   function automatic dbcm_pkg::byte_type mix_byte(input longint a, input longint b,
                                                   input longint f);
      longint sum;
      sum = a * (256 - f) + b * f + 128;
      return dbcm_pkg::byte_type'(sum >> 8);
   endfunction

   // Expected pixel for one level under a given position scale
   function automatic dbcm_pkg::rgb_type colour_of_level(
         input dbcm_pkg::level_type lvl, input logic [dbcm_pkg::SCALE_W-1:0] scale);
      longint            mag;
      longint            pos;
      longint            row;
      longint            frac;
      logic [23:0]       lo;
      logic [23:0]       hi;
      dbcm_pkg::rgb_type c;
      if (lvl >= 0) begin
         c = '{red: 8'hFF, green: 8'hFF, blue: 8'hFF};
         return c;
      end
      mag  = -longint'(lvl);
      pos  = mag * longint'({1'b0, scale});
      row  = pos >> 24;
      frac = (pos >> 16) & 255;
      if (row >= 18) begin
         c = '{red: 8'h00, green: 8'h00, blue: 8'h00};
         return c;
      end
      lo = shade_row(int'(row));
      hi = shade_row(int'(row) + 1);
      c.red   = mix_byte(lo[23:16], hi[23:16], frac);
      c.green = mix_byte(lo[15:8],  hi[15:8],  frac);
      c.blue  = mix_byte(lo[7:0],   hi[7:0],   frac);
      return c;
   endfunction

   // Mostly negative levels inside the table span for this scale, some full-range noise
   function automatic dbcm_pkg::level_type random_level(
         input logic [dbcm_pkg::SCALE_W-1:0] scale);
      longint      reach;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 12)
         return dbcm_pkg::level_type'($urandom_range(0, 262143));
      if (pick < 22)
         return dbcm_pkg::level_type'($urandom);
      if (scale == 0)
         reach = 262144;
      else
         reach = ((longint'(18) << 24) / longint'({1'b0, scale})) + 64;
      if (reach > 262144)
         reach = 262144;
      return dbcm_pkg::level_type'(-longint'($urandom_range(1, int'(reach))));
   endfunction

   function automatic int unsigned gap_draw(input bit calm);
      return calm ? 0 : $urandom_range(0, 11);
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Track the scale register as the block sees it
   always @(posedge clock) begin
      if (reset)
         scale_shadow <= dbcm_pkg::SCALE_RESET;
      else if (csr_write_enable)
         scale_shadow <= csr_write_data;
   end

   // Level driver: hold each beat until taken, then idle for the drawn gap
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid    <= 1'b0;
         req_bus.level_db <= '0;
         req_wait         <= 0;
         req_calm         <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            colour_expect.push_back('{level: req_bus.level_db,
                                      colour: colour_of_level(req_bus.level_db,
                                                              scale_shadow)});
         if (!(req_bus.valid && !req_bus.ready)) begin
            if (req_wait > 0) begin
               req_wait      <= req_wait - 1;
               req_bus.valid <= 1'b0;
            end else if (level_queue.size() != 0) begin
               req_bus.level_db <= level_queue.pop_front();
               req_bus.valid    <= 1'b1;
               req_wait         <= gap_draw(req_calm);
               if ($urandom_range(0, 47) == 0)
                  req_calm <= !req_calm;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Colour monitor: check each beat against the oldest expectation, then stall at random
   always @(posedge clock) begin : colour_check
      int unsigned     gap;
      colour_beat_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_wait      <= 0;
         rsp_calm      <= 1'b0;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         if (colour_expect.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            $display("%0t: colour beat with nothing expected, expected none, actual %0d %0d %0d",
                     $time, rsp_bus.red, rsp_bus.green, rsp_bus.blue);
         end else begin
            want = colour_expect.pop_front();
            if (rsp_bus.red !== want.colour.red || rsp_bus.green !== want.colour.green
                || rsp_bus.blue !== want.colour.blue) begin
               mismatch_count <= mismatch_count + 1;
               $display("%0t: level %0d expected %0d %0d %0d actual %0d %0d %0d",
                        $time, want.level, want.colour.red, want.colour.green,
                        want.colour.blue, rsp_bus.red, rsp_bus.green, rsp_bus.blue);
            end
         end
         gap = gap_draw(rsp_calm);
         rsp_wait      <= gap;
         rsp_bus.ready <= (gap == 0);
         if ($urandom_range(0, 47) == 0)
            rsp_calm <= !rsp_calm;
      end else if (rsp_wait > 0) begin
         rsp_wait      <= rsp_wait - 1;
         rsp_bus.ready <= (rsp_wait == 1);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Wait until every level is sent and every colour has come back
   task automatic settle();
      while (level_queue.size() != 0 || req_bus.valid || colour_expect.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_scale(input logic [dbcm_pkg::SCALE_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Field extremes, -1 and 0, plus a batch of random levels for the current scale
   task automatic load_phase(input logic [dbcm_pkg::SCALE_W-1:0] scale);
      level_queue.push_back(LEVEL_LOW);
      level_queue.push_back(dbcm_pkg::level_type'(-1));
      level_queue.push_back(dbcm_pkg::level_type'(0));
      level_queue.push_back(LEVEL_HIGH);
      repeat (PHASE_BEATS)
         level_queue.push_back(random_level(scale));
   endtask

   initial begin : stimulus
      logic [dbcm_pkg::SCALE_W-1:0] scale_plan [$];
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed levels at the reset scale: white, whole and part rows, last row, black edge
      level_queue.push_back(dbcm_pkg::level_type'(1));
      level_queue.push_back(dbcm_pkg::level_type'(256));
      level_queue.push_back(dbcm_pkg::level_type'(-128));
      level_queue.push_back(dbcm_pkg::level_type'(-256));
      level_queue.push_back(dbcm_pkg::level_type'(-1280));
      level_queue.push_back(dbcm_pkg::level_type'(-2560));
      level_queue.push_back(dbcm_pkg::level_type'(-12345));
      level_queue.push_back(dbcm_pkg::level_type'(-23040));
      level_queue.push_back(dbcm_pkg::level_type'(-43520));
      level_queue.push_back(dbcm_pkg::level_type'(-46054));
      level_queue.push_back(dbcm_pkg::level_type'(-46080));
      level_queue.push_back(dbcm_pkg::level_type'(-46081));
      load_phase(dbcm_pkg::SCALE_RESET);
      settle();

      // Sweep the scale: extremes, zero, reset value, 2048 and 36, then three random settings
      scale_plan.push_back(16'hFFFF);
      scale_plan.push_back(16'd1);
      scale_plan.push_back(16'd0);
      scale_plan.push_back(dbcm_pkg::SCALE_RESET);
      scale_plan.push_back(16'd2048);
      scale_plan.push_back(16'd36);
      repeat (3)
         scale_plan.push_back(dbcm_pkg::SCALE_W'($urandom_range(1, 65535)));
      foreach (scale_plan[i]) begin
         write_scale(scale_plan[i]);
         load_phase(scale_plan[i]);
         settle();
      end

      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
